// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each user module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PDMA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pdma assertion failed");

// Checked at every clock edge, reset included.
`define PDMA_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pdma reset assertion failed");

`endif

// ===== sv/pdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pdma_pkg;

    localparam int RAW_W = 24;
    localparam int SAMPLE_W = 17;
    localparam int MBAR_W = 18;
    localparam int DEPTH_W = 25;

    localparam int WINDOW_DEF = 10;

    // Pressure code to mbar: truncating division of the magnitude by 100.
    localparam int PRES_DIV = 100;
    localparam int PRES_SHIFT = 30;
    localparam logic [RAW_W-1:0] PRES_RECIP =
        RAW_W'(((64'd1 << PRES_SHIFT) + 64'(PRES_DIV) - 64'd1) / 64'(PRES_DIV));

    // Depth scale: floor(diff * 25600 / 98) = floor(diff * 12800 / 49).
    localparam int DEPTH_NUM = 12800;
    localparam int DEPTH_DEN = 49;
    localparam int DEPTH_SHIFT = 23;
    localparam int DEPTH_RECIP_W = 32;
    localparam logic [DEPTH_RECIP_W-1:0] DEPTH_RECIP =
        DEPTH_RECIP_W'(((64'(DEPTH_NUM) << DEPTH_SHIFT) + 64'(DEPTH_DEN) - 64'd1)
                       / 64'(DEPTH_DEN));

    typedef struct packed {
        logic signed [MBAR_W-1:0] mbar;
        logic signed [RAW_W-1:0]  temp;
    } pdma_meta_t;

endpackage

`default_nettype wire

// ===== sv/pdma_mbar.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdma_mbar
    import pdma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    up_valid,
    output logic                    up_load,
    input  logic signed [RAW_W-1:0] pressure_raw,
    input  logic signed [RAW_W-1:0] temperature_raw,
    input  logic                    dn_load,
    output logic                    dn_valid,
    output pdma_meta_t              dn_meta,
    output logic [SAMPLE_W-1:0]     dn_sample
);

    localparam int PROD_W = 2 * RAW_W;

    logic                    v0_reg;
    logic signed [RAW_W-1:0] p0_reg;
    logic signed [RAW_W-1:0] t0_reg;
    logic                    v1_reg;
    logic [PROD_W-1:0]       prod1_reg;
    logic                    neg1_reg;
    logic signed [RAW_W-1:0] t1_reg;
    logic                    v2_reg;
    pdma_meta_t              meta2_reg;
    logic [SAMPLE_W-1:0]     sample2_reg;

    logic                    load0;
    logic                    load1;
    logic                    load2;
    logic                    neg0;
    logic [RAW_W-1:0]        mag0;
    logic [PROD_W-1:0]       prod1_next;
    logic [SAMPLE_W-1:0]     quot1;
    logic [MBAR_W-1:0]       quot1_ext;
    logic [MBAR_W-1:0]       mbar2_next;
    logic [SAMPLE_W-1:0]     sample2_next;

    assign load2 = !v2_reg || dn_load;
    assign load1 = !v1_reg || load2;
    assign load0 = !v0_reg || load1;
    assign up_load = load0;

    assign neg0 = p0_reg[RAW_W-1];
    assign mag0 = neg0 ? RAW_W'(-p0_reg) : RAW_W'(p0_reg);
    assign prod1_next = PROD_W'(mag0) * PROD_W'(PRES_RECIP);

    assign quot1 = prod1_reg[PRES_SHIFT +: SAMPLE_W];
    assign quot1_ext = {1'b0, quot1};
    assign mbar2_next = neg1_reg ? (~quot1_ext + MBAR_W'(1)) : quot1_ext;
    assign sample2_next = neg1_reg ? '0 : quot1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (load0)
            begin
                v0_reg <= up_valid;
            end
            if (load1)
            begin
                v1_reg <= v0_reg;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            p0_reg <= pressure_raw;
            t0_reg <= temperature_raw;
        end
        if (load1)
        begin
            prod1_reg <= prod1_next;
            neg1_reg <= neg0;
            t1_reg <= t0_reg;
        end
        if (load2)
        begin
            meta2_reg.mbar <= mbar2_next;
            meta2_reg.temp <= t1_reg;
            sample2_reg <= sample2_next;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_meta = meta2_reg;
    assign dn_sample = sample2_reg;

    `PDMA_ASSERT(a_sample_not_negative, (v2_reg && sample2_reg != '0) |-> !meta2_reg.mbar[MBAR_W-1])

endmodule

`default_nettype wire

// ===== sv/pdma_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdma_window
    import pdma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_load,
    input  pdma_meta_t          up_meta,
    input  logic [SAMPLE_W-1:0] up_sample,
    input  logic                dn_load,
    output logic                dn_valid,
    output pdma_meta_t          dn_meta,
    output logic [SUM_W-1:0]    dn_sum
);

    logic [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                valid_reg;
    pdma_meta_t          meta_reg;
    logic                load;
    logic                take;

    assign load = !valid_reg || dn_load;
    assign take = load && up_valid;
    assign up_load = load;

    // The oldest sample leaves the sum as the newest one enters.
    assign sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(up_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sum_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (load)
            begin
                valid_reg <= up_valid;
            end
            if (take)
            begin
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WINDOW-1] <= up_sample;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meta_reg <= up_meta;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_meta = meta_reg;
    assign dn_sum = sum_reg;

    `PDMA_ASSERT(a_sum_moves_only_on_request, !take |=> $stable(sum_reg))

endmodule

`default_nettype wire

// ===== sv/pdma_depth.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pdma_depth
    import pdma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_load,
    input  pdma_meta_t               up_meta,
    input  logic [SUM_W-1:0]         up_sum,
    input  logic [SAMPLE_W-1:0]      baseline,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [DEPTH_W-1:0]       depth_q8,
    output logic signed [MBAR_W-1:0] pressure_mbar,
    output logic signed [RAW_W-1:0]  temperature_centi
);

    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int AVG_RECIP_W = SUM_W + 1;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;
    localparam int DEPTH_PROD_W = SAMPLE_W + DEPTH_RECIP_W;

    logic                    v4_reg;
    logic [AVG_PROD_W-1:0]   avgp4_reg;
    pdma_meta_t              meta4_reg;
    logic                    v5_reg;
    logic [DEPTH_PROD_W-1:0] dprod5_reg;
    pdma_meta_t              meta5_reg;
    logic                    ov_reg;
    logic [DEPTH_W-1:0]      depth_reg;
    pdma_meta_t              ometa_reg;

    logic                    load4;
    logic                    load5;
    logic                    load_out;
    logic [AVG_PROD_W-1:0]   avgp4_next;
    logic [SAMPLE_W-1:0]     avg4;
    logic [SAMPLE_W-1:0]     diff4;
    logic [DEPTH_PROD_W-1:0] dprod5_next;

    assign load_out = !ov_reg || !out_stall;
    assign load5 = !v5_reg || load_out;
    assign load4 = !v4_reg || load5;
    assign up_load = load4;

    assign avgp4_next = AVG_PROD_W'(up_sum) * AVG_PROD_W'(AVG_RECIP);

    assign avg4 = avgp4_reg[AVG_SHIFT +: SAMPLE_W];
    assign diff4 = (avg4 > baseline) ? (avg4 - baseline) : '0;
    assign dprod5_next = DEPTH_PROD_W'(diff4) * DEPTH_PROD_W'(DEPTH_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (load4)
            begin
                v4_reg <= up_valid;
            end
            if (load5)
            begin
                v5_reg <= v4_reg;
            end
            if (load_out)
            begin
                ov_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            avgp4_reg <= avgp4_next;
            meta4_reg <= up_meta;
        end
        if (load5)
        begin
            dprod5_reg <= dprod5_next;
            meta5_reg <= meta4_reg;
        end
        if (load_out)
        begin
            depth_reg <= dprod5_reg[DEPTH_SHIFT +: DEPTH_W];
            ometa_reg <= meta5_reg;
        end
    end

    assign out_valid = ov_reg;
    assign depth_q8 = depth_reg;
    assign pressure_mbar = ometa_reg.mbar;
    assign temperature_centi = ometa_reg.temp;

endmodule

`default_nettype wire

// ===== sv/pressure_depth_moving_average.sv =====
// Converts each pressure request to mbar, keeps a moving average over the last WINDOW
// samples (negative readings count as zero), subtracts the programmed surface baseline
// and reports depth in unsigned Q.8 alongside the mbar reading and the temperature
// passed through. The pipeline takes one request per clock while in_stall is low; an
// empty stage ahead of a stalled output still accepts, so requests keep coming in
// until every stage holds one. The window starts all zero after reset, so the average
// ramps up over the first WINDOW requests.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pressure_depth_moving_average
    import pdma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [RAW_W-1:0]  pressure_raw,
    input  logic signed [RAW_W-1:0]  temperature_raw,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DEPTH_W-1:0]       depth_q8,
    output logic signed [MBAR_W-1:0] pressure_mbar,
    output logic signed [RAW_W-1:0]  temperature_centi,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SAMPLE_W-1:0]      baseline_mbar
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    logic [SAMPLE_W-1:0] baseline_reg;
    logic                mb_load;
    logic                mb_valid;
    pdma_meta_t          mb_meta;
    logic [SAMPLE_W-1:0] mb_sample;
    logic                win_load;
    logic                win_valid;
    pdma_meta_t          win_meta;
    logic [SUM_W-1:0]    win_sum;
    logic                dp_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
        end
        else if (cfg_valid)
        begin
            baseline_reg <= baseline_mbar;
        end
    end

    pdma_mbar u_mbar (
        .clk             (clk),
        .rst_n           (rst_n),
        .up_valid        (in_valid),
        .up_load         (mb_load),
        .pressure_raw    (pressure_raw),
        .temperature_raw (temperature_raw),
        .dn_load         (win_load),
        .dn_valid        (mb_valid),
        .dn_meta         (mb_meta),
        .dn_sample       (mb_sample)
    );

    pdma_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (mb_valid),
        .up_load   (win_load),
        .up_meta   (mb_meta),
        .up_sample (mb_sample),
        .dn_load   (dp_load),
        .dn_valid  (win_valid),
        .dn_meta   (win_meta),
        .dn_sum    (win_sum)
    );

    pdma_depth #(
        .WINDOW (WINDOW)
    ) u_depth (
        .clk               (clk),
        .rst_n             (rst_n),
        .up_valid          (win_valid),
        .up_load           (dp_load),
        .up_meta           (win_meta),
        .up_sum            (win_sum),
        .baseline          (baseline_reg),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .depth_q8          (depth_q8),
        .pressure_mbar     (pressure_mbar),
        .temperature_centi (temperature_centi)
    );

    assign in_stall = !mb_load;

    `PDMA_ASSERT(a_stall_only_when_full, in_stall |-> (out_valid && out_stall))
    `PDMA_ASSERT_RST(a_reset_empties_output, !rst_n |=> !out_valid)

endmodule

`default_nettype wire
